[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int ENTRY_W = VALUE_W + PRIO_W;
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Memory read address select
  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_KM1  = 3'd1;
  localparam logic [2:0] RD_KM2  = 3'd2;
  localparam logic [2:0] RD_KP1  = 3'd3;
  localparam logic [2:0] RD_KP2  = 3'd4;
  localparam logic [2:0] RD_HEAD = 3'd5;

  // Memory write select (always at slot of cursor)
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_RDATA = 2'd1;
  localparam logic [1:0] WR_NEW   = 2'd2;

  // Head and count update
  localparam logic [2:0] UPD_NONE = 3'd0;
  localparam logic [2:0] UPD_PUSH = 3'd1;
  localparam logic [2:0] UPD_POP  = 3'd2;
  localparam logic [2:0] UPD_REM  = 3'd3;
  localparam logic [2:0] UPD_CLR  = 3'd4;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [VALUE_W-1:0]       value;
  } entry_t;

  typedef struct packed {
    logic              load;
    logic [2:0]        rd_sel;
    logic [1:0]        wr_sel;
    logic [2:0]        upd;
    logic              k_dec;
    logic              k_inc;
    logic              status_we;
    logic [STAT_W-1:0] status_code;
    logic              load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_zero;
    logic            full;
    logic            pos_bad;
    logic            k_one;
    logic            prio_le;
    logic            rem_more;
    logic            rem_more2;
    logic            out_busy;
  } dp_stat_t;

endpackage

[rtl/core/spq_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: one operation per beat.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [VALUE_W-1:0]       item_value;
  logic signed [PRIO_W-1:0] item_priority;
  logic [POS_W-1:0]         position;

  modport source (output valid, operation, item_value, item_priority, position,
                  input ready);
  modport sink   (input valid, operation, item_value, item_priority, position,
                  output ready);
endinterface

[rtl/core/spq_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel: status, count and head pair per beat.
// ----------------------------------------------------------------------------
interface spq_rsp_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       entry_count;
  logic [VALUE_W-1:0]       head_value;
  logic signed [PRIO_W-1:0] head_priority;
  logic                     head_valid;

  modport source (output valid, status, entry_count, head_value, head_priority,
                  head_valid, input ready);
  modport sink   (input valid, status, entry_count, head_value, head_priority,
                  head_valid, output ready);
endinterface

[rtl/core/spq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/spq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: dispatches operations and steps the shift loops.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_PUSH     = 3'd2;
  localparam logic [2:0] S_PLACE    = 3'd3;
  localparam logic [2:0] S_REMOVE   = 3'd4;
  localparam logic [2:0] S_HEAD     = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.rd_sel      = RD_NONE;
    cmd.wr_sel      = WR_NONE;
    cmd.upd         = UPD_NONE;
    cmd.status_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.status_we = 1'b1;
        state_next    = S_HEAD;
        case (st.op)
          OP_PUSH: begin
            if (st.full) begin
              cmd.status_code = ST_FULL;
            end else if (st.count_zero) begin
              cmd.wr_sel = WR_NEW;
              cmd.upd    = UPD_PUSH;
            end else begin
              cmd.rd_sel = RD_KM1;
              state_next = S_PUSH;
            end
          end
          OP_POP: begin
            if (st.count_zero) begin
              cmd.status_code = ST_EMPTY;
            end else begin
              cmd.upd = UPD_POP;
            end
          end
          OP_REMOVE: begin
            if (st.pos_bad) begin
              cmd.status_code = ST_RANGE;
            end else if (st.rem_more) begin
              cmd.rd_sel = RD_KP1;
              state_next = S_REMOVE;
            end else begin
              cmd.upd = UPD_REM;
            end
          end
          OP_CLEAR: begin
            cmd.upd = UPD_CLR;
          end
          default: begin
            cmd.upd = UPD_NONE;
          end
        endcase
      end
      S_PUSH: begin
        // shift the entry up while the new one is not greater
        if (st.prio_le) begin
          cmd.wr_sel = WR_RDATA;
          cmd.k_dec  = 1'b1;
          if (st.k_one) begin
            state_next = S_PLACE;
          end else begin
            cmd.rd_sel = RD_KM2;
          end
        end else begin
          cmd.wr_sel = WR_NEW;
          cmd.upd    = UPD_PUSH;
          state_next = S_HEAD;
        end
      end
      S_PLACE: begin
        cmd.wr_sel = WR_NEW;
        cmd.upd    = UPD_PUSH;
        state_next = S_HEAD;
      end
      S_REMOVE: begin
        cmd.wr_sel = WR_RDATA;
        cmd.k_inc  = 1'b1;
        if (st.rem_more2) begin
          cmd.rd_sel = RD_KP2;
        end else begin
          cmd.upd    = UPD_REM;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.rd_sel = RD_HEAD;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/spq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: ring pointers, cursor, entry memory and result register.
// ----------------------------------------------------------------------------
module spq_dp import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [OP_W-1:0]          operation,
  input  logic [VALUE_W-1:0]       item_value,
  input  logic signed [PRIO_W-1:0] item_priority,
  input  logic [POS_W-1:0]         position,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 st,
  spq_rsp_if.source                result
);

  localparam int SW = $clog2(CAPACITY);
  localparam int KW = $clog2(CAPACITY + 1);
  localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);
  localparam logic [KW:0]   CAP_W = (KW + 1)'(CAPACITY);

  logic [SW-1:0]            head;
  logic [KW-1:0]            count;
  logic [KW-1:0]            k;
  logic [OP_W-1:0]          op;
  logic [VALUE_W-1:0]       new_value;
  logic signed [PRIO_W-1:0] new_prio;
  logic [POS_W-1:0]         pos;
  logic [STAT_W-1:0]        op_status;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [COUNT_W-1:0]       out_count;
  logic [VALUE_W-1:0]       out_value;
  logic signed [PRIO_W-1:0] out_prio;
  logic                     out_hv;

  logic [KW:0]        kx;
  logic [SW-1:0]      raddr;
  logic [SW-1:0]      waddr;
  logic               re;
  logic               we;
  entry_t             wentry;
  entry_t             rentry;
  logic [ENTRY_W-1:0] rdata;

  // ring slot of an offset from the head; offset never exceeds the capacity
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] h,
                                            input logic [KW:0] off);
    logic [KW:0] sum;
    sum = (KW + 1)'(h) + off;
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return SW'(sum);
  endfunction

  assign kx     = {1'b0, k};
  assign rentry = entry_t'(rdata);

  always_comb begin
    re = 1'b1;
    case (cmd.rd_sel)
      RD_KM1:  raddr = slot_of(head, kx - (KW + 1)'(1));
      RD_KM2:  raddr = slot_of(head, kx - (KW + 1)'(2));
      RD_KP1:  raddr = slot_of(head, kx + (KW + 1)'(1));
      RD_KP2:  raddr = slot_of(head, kx + (KW + 1)'(2));
      RD_HEAD: raddr = head;
      default: begin
        raddr = head;
        re    = 1'b0;
      end
    endcase
  end

  always_comb begin
    waddr = slot_of(head, kx);
    we    = (cmd.wr_sel != WR_NONE);
    if (cmd.wr_sel == WR_NEW) begin
      wentry.value = new_value;
      wentry.prio  = new_prio;
    end else begin
      wentry = rentry;
    end
  end

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status towards the sequencer
  always_comb begin
    st.op         = op;
    st.count_zero = (count == '0);
    st.full       = (count == CAP_K);
    st.pos_bad    = ((KW + POS_W)'(pos) >= (KW + POS_W)'(count));
    st.k_one      = (k == KW'(1));
    st.prio_le    = (new_prio <= rentry.prio);
    st.rem_more   = ((kx + (KW + 1)'(1)) < {1'b0, count});
    st.rem_more2  = ((kx + (KW + 1)'(2)) < {1'b0, count});
    st.out_busy   = out_valid && !result.ready;
  end

  // latched request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= operation;
      new_value <= item_value;
      new_prio  <= item_priority;
      pos       <= position;
    end
    if (cmd.status_we) begin
      op_status <= cmd.status_code;
    end
  end

  // cursor: count for push, position for remove
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k <= (operation == OP_REMOVE) ? KW'(position) : count;
    end else if (cmd.k_dec) begin
      k <= k - KW'(1);
    end else if (cmd.k_inc) begin
      k <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      case (cmd.upd)
        UPD_PUSH: count <= count + KW'(1);
        UPD_POP: begin
          head  <= slot_of(head, (KW + 1)'(1));
          count <= count - KW'(1);
        end
        UPD_REM:  count <= count - KW'(1);
        UPD_CLR: begin
          head  <= '0;
          count <= '0;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_status <= op_status;
      out_count  <= COUNT_W'(count);
      out_hv     <= (count != '0);
      out_value  <= (count != '0) ? rentry.value : '0;
      out_prio   <= (count != '0) ? rentry.prio : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.entry_count   = out_count;
  assign result.head_value    = out_value;
  assign result.head_priority = out_prio;
  assign result.head_valid    = out_hv;

endmodule

[rtl/core/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// Sequence: a push shifts entries up from the tail, at most CAPACITY - 1 of them, until
//   its slot is found (no shift into an empty queue); a remove shifts the entries past
//   its position down; pop, clear and refused beats skip the shift loop. The one-port-read
//   shift loop sets how long a push or remove takes to reach the result beat.
// Throughput: one request at a time; the next request beat is taken as soon as the
//   result sits in the output register, even before it has been taken.
// Reset: synchronous, clears count, head slot and handshake state; no memory sweep.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted-array priority queue held in a ring buffer in one RAM.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   request,
  spq_rsp_if.source result
);

  // Command and status between the sequencer and the datapath
  dp_cmd_t  cmd;
  dp_stat_t st;

  // Sequencer: takes a request beat, walks the shift loop, then waits for
  // the result register to drain before loading its result.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: ring head, entry count, shift cursor, entry RAM and the
  // registered result. Entries past the occupied span are never used, so
  // the RAM needs no clearing.
  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .operation     (request.operation),
    .item_value    (request.item_value),
    .item_priority (request.item_priority),
    .position      (request.position),
    .cmd           (cmd),
    .st            (st),
    .result        (result)
  );

endmodule

[tb/sorted_priority_queue_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// Self-checking bench for the sorted priority queue core. Each request beat
// is predicted on acceptance by a ring model of the queue, and every result
// beat is compared field by field with the oldest prediction. Directed cases
// cover the edges; random traffic under varied handshake idling and a long
// result hold-off covers the rest.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int CAPACITY     = 16;
  // Longest request-to-result path is a push that shifts every entry.
  localparam int SETTLE_TICKS = 6 + CAPACITY + 10;
  localparam int HOLD_TICKS   = 300;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
    logic [VALUE_W-1:0]       head_value;
    logic signed [PRIO_W-1:0] head_priority;
    logic                     head_valid;
  } queue_result_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_core #(
    .CAPACITY (CAPACITY)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  // Ring model of the queue: slots, head slot and occupancy.
  entry_t      model_ring [CAPACITY];
  int unsigned model_head;
  int unsigned model_count;

  // Results predicted but not yet seen on the result channel, oldest first.
  queue_result_t pending_results [$];

  // Idle rates in percent, per side; the hold-off counter belongs to the
  // result process, which counts it down.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  int fail_count;
  int ops_sent    [4];
  int status_seen [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned ring_slot(int unsigned offset);
    return (model_head + offset) % CAPACITY;
  endfunction

  // Apply one operation to the ring model and return the result it causes.
  function automatic queue_result_t predict_queue_result(
    logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
    logic signed [PRIO_W-1:0] prio, logic [POS_W-1:0] pos);
    queue_result_t r;
    int unsigned   p;
    int unsigned   k;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // Stop at the first entry that is not lower: ties go in front.
          p = 0;
          while (p < model_count && prio > model_ring[ring_slot(p)].prio) p++;
          for (k = model_count; k > p; k--)
            model_ring[ring_slot(k)] = model_ring[ring_slot(k - 1)];
          model_ring[ring_slot(p)].prio  = prio;
          model_ring[ring_slot(p)].value = value;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_head = ring_slot(1);
          model_count--;
        end
      end
      OP_REMOVE: begin
        if (32'(pos) >= model_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = 32'(pos); k + 1 < model_count; k++)
            model_ring[ring_slot(k)] = model_ring[ring_slot(k + 1)];
          model_count--;
        end
      end
      OP_CLEAR: begin
        model_count = 0;
        model_head  = 0;
      end
    endcase
    r.entry_count = COUNT_W'(model_count);
    if (model_count > 0) begin
      r.head_value    = model_ring[model_head].value;
      r.head_priority = model_ring[model_head].prio;
      r.head_valid    = 1'b1;
    end
    return r;
  endfunction

  // Offer one request beat, after a random idle gap, and predict it on
  // acceptance. Valid stays high on return so back-to-back beats need no
  // second assignment in the same step.
  task automatic send_beat(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                           logic signed [PRIO_W-1:0] prio, logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.item_value    <= value;
    req_ch.item_priority <= prio;
    req_ch.position      <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_queue_result(op, value, prio, pos));
    ops_sent[op]++;
  endtask

  // Drop valid, then hold until every predicted result has arrived and the
  // block has had time to settle.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: sample each beat at the edge, compare it with the oldest
  // prediction, then choose ready for the next cycle.
  initial begin : result_checker
    queue_result_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no pending prediction: status %0d count %0d",
                 rsp_ch.status, rsp_ch.entry_count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          check_field("status", 32'(want.status), 32'(rsp_ch.status));
          check_field("entry_count", 32'(want.entry_count), 32'(rsp_ch.entry_count));
          check_field("head_value", want.head_value, rsp_ch.head_value);
          check_field("head_priority", 32'(want.head_priority),
                      32'(rsp_ch.head_priority));
          check_field("head_valid", 32'(want.head_valid), 32'(rsp_ch.head_valid));
        end
      end
      // Honour a long hold-off first, else idle at the current rate.
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Refused operations on an empty queue, extreme fields, equal priorities
  // served newest first, remove in and out of range, and clear.
  task automatic test_directed_edges();
    send_beat(OP_POP,    32'h0,          16'sh0,    4'd0);
    send_beat(OP_REMOVE, 32'h0,          16'sh0,    4'd0);
    send_beat(OP_REMOVE, 32'h0,          16'sh0,    4'd15);
    send_beat(OP_PUSH,   32'h0000_0000,  -16'sd32768, 4'd0);
    send_beat(OP_PUSH,   32'hFFFF_FFFF,  16'sd32767,  4'd15);
    send_beat(OP_PUSH,   32'h1111_1111,  16'sd0,      4'd0);
    send_beat(OP_PUSH,   32'h2222_2222,  16'sd0,      4'd0);
    send_beat(OP_PUSH,   32'hA5A5_5A5A,  -16'sd1,     4'd0);
    send_beat(OP_POP,    32'h0,          16'sh0,      4'd0);
    send_beat(OP_REMOVE, 32'h0,          16'sh0,      4'd1);
    send_beat(OP_REMOVE, 32'h0,          16'sh0,      4'd3);
    send_beat(OP_REMOVE, 32'h0,          16'sh0,      4'd2);
    send_beat(OP_CLEAR,  32'h0,          16'sh0,      4'd0);
    send_beat(OP_POP,    32'h0,          16'sh0,      4'd0);
    send_beat(OP_CLEAR,  32'h0,          16'sh0,      4'd0);
  endtask

  // Fill to capacity, refuse a push when full, remove the last entry, try
  // the now stale position, then remove the head.
  task automatic test_fill_to_capacity();
    repeat (CAPACITY) send_beat(OP_PUSH, $urandom, PRIO_W'($urandom_range(7)), 4'd0);
    send_beat(OP_PUSH,   32'hDEAD_0001, -16'sd32768, 4'd0);
    send_beat(OP_REMOVE, 32'h0, 16'sh0, 4'd15);
    send_beat(OP_REMOVE, 32'h0, 16'sh0, 4'd15);
    send_beat(OP_REMOVE, 32'h0, 16'sh0, 4'd0);
    send_beat(OP_PUSH,   32'hFFFF_FFFF, 16'sd32767, 4'd0);
    send_beat(OP_CLEAR,  32'h0, 16'sh0, 4'd0);
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the core stalls its input; then pause the sender until all is back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = HOLD_TICKS;
    repeat (12) send_beat(OP_PUSH, $urandom, PRIO_W'($urandom), 4'd0);
    wait_drained();
    repeat (6) send_beat(OP_POP, 32'h0, 16'sh0, 4'd0);
    send_beat(OP_CLEAR, 32'h0, 16'sh0, 4'd0);
  endtask

  // One random beat. Mostly well-formed traffic: positions chiefly inside the
  // occupied span, priorities drawn to give ties, extremes and spread.
  task automatic send_random_beat(int push_pct);
    logic [OP_W-1:0]          op;
    logic [VALUE_W-1:0]       val;
    logic signed [PRIO_W-1:0] pri;
    logic [POS_W-1:0]         pos;
    int                       roll;
    roll = $urandom_range(99);
    if (roll < 3)                   op = OP_CLEAR;
    else if (roll < 3 + push_pct)   op = OP_PUSH;
    else if ($urandom_range(1) != 0) op = OP_POP;
    else                            op = OP_REMOVE;

    case ($urandom_range(3))
      0: pri = PRIO_W'(int'($urandom_range(7)) - 4);
      1: begin
        case ($urandom_range(2))
          0: pri = -16'sd32768;
          1: pri = 16'sd32767;
          default: pri = 16'sd0;
        endcase
      end
      default: pri = PRIO_W'($urandom);
    endcase

    val = ($urandom_range(15) == 0) ? {VALUE_W{$urandom_range(1) == 1}} : $urandom;

    if (model_count > 0 && $urandom_range(4) != 0) pos = POS_W'($urandom_range(model_count - 1));
    else pos = POS_W'($urandom);

    send_beat(op, val, pri, pos);
  endtask

  // Alternate filling and draining stretches so the queue sweeps from empty
  // to full and back, wrapping the ring on the way.
  task automatic test_random_traffic(int send_pct, int recv_pct, int beats);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < beats; i++)
      send_random_beat(((i / 40) % 2 == 0) ? 75 : 25);
    wait_drained();
  endtask

  initial begin : test_sequence
    fail_count    = 0;
    hold_cycles   = 0;
    send_idle_pct = 23;
    recv_idle_pct = 86;
    model_head    = 0;
    model_count   = 0;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (model_ring[i]) model_ring[i] = '0;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_PUSH;
    req_ch.item_value    <= '0;
    req_ch.item_priority <= '0;
    req_ch.position      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_fill_to_capacity();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_traffic(23, 86, 480);
    test_random_traffic(86, 23, 480);
    test_random_traffic(0, 0, 480);
    wait_drained();

    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      fail_count++;
    end

    $display("covered beats: push %0d, pop %0d, remove %0d, clear %0d",
             ops_sent[OP_PUSH], ops_sent[OP_POP], ops_sent[OP_REMOVE], ops_sent[OP_CLEAR]);
    $display("refusals seen: full %0d, empty %0d, out of range %0d; mismatches %0d",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_RANGE], fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/spq_pkg.sv
rtl/core/spq_req_if.sv
rtl/core/spq_rsp_if.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_dp.sv
rtl/core/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_test.sv
